/* hdl/infix_add_mul_evaluator_defines.svh */
// ----------------------------------------------------------------------------
// infix_add_mul_evaluator_defines.svh
// Assertion macros used by the checker file of the evaluator.
// ----------------------------------------------------------------------------
`ifndef INFIX_ADD_MUL_EVALUATOR_DEFINES_SVH
`define INFIX_ADD_MUL_EVALUATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IAME_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IAME_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/iame_pkg.sv */
// ----------------------------------------------------------------------------
// iame_pkg
// Operator codes, controller states and the command and status bundles
// that join the controller and the datapath of the evaluator.
// ----------------------------------------------------------------------------
package iame_pkg;

  // Width of the operand and value ports.
  localparam int unsigned PORT_WIDTH = 64;

  // Operator codes carried on op_i.
  localparam logic [2:0] OP_PLUS   = 3'd0;
  localparam logic [2:0] OP_MINUS  = 3'd1;
  localparam logic [2:0] OP_TIMES  = 3'd2;
  localparam logic [2:0] OP_DIVIDE = 3'd3;
  localparam logic [2:0] OP_EQUALS = 3'd4;

  // Operator waiting to combine the product term with the next operand.
  typedef enum logic [1:0] {
    MD_NONE   = 2'd0,
    MD_TIMES  = 2'd1,
    MD_DIVIDE = 2'd2
  } md_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CALC  = 3'b010,
    ST_APPLY = 3'b100
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // Capture an accepted transaction and set up the iteration.
    logic step;   // Run one multiply or divide iteration.
    logic apply;  // Fold the finished term into the expression state.
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_ok;       // op_i holds a defined operator.
    logic md_pending;  // A times or divide chain waits for the operand.
    logic calc_done;   // The current iteration is the last one.
    logic apply_ok;    // The result slot can take the apply.
  } ctl_sts_t;

endpackage

/* hdl/iame_datapath.sv */
// ----------------------------------------------------------------------------
// iame_datapath
// Expression state, a shared shift-add multiplier and restoring divider
// working one bit per cycle, and the result register.
// ----------------------------------------------------------------------------
module iame_datapath import iame_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctl_cmd_t              cmd_i,
  output ctl_sts_t              sts_o,
  input  logic [PORT_WIDTH-1:0] operand_i,
  input  logic [2:0]            op_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PORT_WIDTH-1:0] value_o,
  output logic                  divide_error_o
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned CW = (W > 1) ? $clog2(W) : 1;

  // Expression state.
  logic [W-1:0] total_q, prod_q;
  md_e          pend_md_q;
  logic         pend_sub_q, err_q;

  // Captured transaction and iteration registers.
  logic [W-1:0]  x_q;
  logic [2:0]    op_q;
  logic [W-1:0]  acc_q;
  logic [W-1:0]  opnd_q, sh_q;
  logic [CW-1:0] cnt_q;
  logic          neg_q, dz_q;

  // Result register.
  logic [W-1:0] value_q;
  logic         derr_q, out_valid_q;

  logic [W-1:0] x, prod_mag, x_mag;
  logic [W:0]   rem_sh;
  logic [W-1:0] rem_sub;
  logic         rem_ge;
  logic [W-1:0] term_mag, term_val, sum;
  logic         term_neg, sub_eff, dz_div, out_free;

  assign x        = operand_i[W-1:0];
  assign prod_mag = prod_q[W-1] ? ({W{1'b0}} - prod_q) : prod_q;
  assign x_mag    = x[W-1] ? ({W{1'b0}} - x) : x;

  // One restoring division step on the shifted partial remainder.
  assign rem_sh  = {acc_q, sh_q[W-1]};
  assign rem_ge  = rem_sh >= {1'b0, opnd_q};
  assign rem_sub = rem_sh[W-1:0] - opnd_q;

  // Select the finished term as magnitude and sign.
  always_comb begin
    term_mag = x_q;
    term_neg = 1'b0;
    case (pend_md_q)
      MD_TIMES: term_mag = acc_q;
      MD_DIVIDE: begin
        term_mag = dz_q ? {W{1'b0}} : sh_q;
        term_neg = neg_q && !dz_q;
      end
      default: term_mag = x_q;
    endcase
  end

  assign dz_div   = (pend_md_q == MD_DIVIDE) && dz_q;
  assign term_val = term_neg ? ({W{1'b0}} - term_mag) : term_mag;
  assign sub_eff  = pend_sub_q ^ term_neg;
  assign sum      = sub_eff ? (total_q - term_mag) : (total_q + term_mag);
  assign out_free = !out_valid_q || !out_stall_i;

  // Status toward the controller.
  assign sts_o.op_ok      = op_i <= OP_EQUALS;
  assign sts_o.md_pending = (pend_md_q == MD_TIMES) || (pend_md_q == MD_DIVIDE);
  assign sts_o.calc_done  = cnt_q == '0;
  assign sts_o.apply_ok   = (op_q != OP_EQUALS) || out_free;

  // Capture the transaction and run the iterations.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q   <= x;
      op_q  <= op_i;
      cnt_q <= CW'(W - 1);
      acc_q <= '0;
      neg_q <= prod_q[W-1] ^ x[W-1];
      dz_q  <= x == '0;
      if (pend_md_q == MD_DIVIDE) begin
        opnd_q <= x_mag;
        sh_q   <= prod_mag;
      end else begin
        opnd_q <= prod_q;
        sh_q   <= x;
      end
    end else if (cmd_i.step) begin
      cnt_q <= cnt_q - 1'b1;
      if (pend_md_q == MD_DIVIDE) begin
        acc_q <= rem_ge ? rem_sub : rem_sh[W-1:0];
        sh_q  <= {sh_q[W-2:0], rem_ge};
      end else begin
        if (sh_q[0]) begin
          acc_q <= acc_q + opnd_q;
        end
        opnd_q <= {opnd_q[W-2:0], 1'b0};
        sh_q   <= {1'b0, sh_q[W-1:1]};
      end
    end
  end

  // Expression state and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      prod_q      <= '0;
      pend_md_q   <= MD_NONE;
      pend_sub_q  <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // A new result replaces one that leaves in the same cycle.
      if (cmd_i.apply && (op_q == OP_EQUALS)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.apply) begin
        case (op_q) inside
          OP_TIMES, OP_DIVIDE: begin
            prod_q    <= term_val;
            pend_md_q <= (op_q == OP_TIMES) ? MD_TIMES : MD_DIVIDE;
            err_q     <= err_q | dz_div;
          end
          OP_EQUALS: begin
            total_q    <= '0;
            prod_q     <= '0;
            pend_md_q  <= MD_NONE;
            pend_sub_q <= 1'b0;
            err_q      <= 1'b0;
          end
          default: begin
            total_q    <= sum;
            prod_q     <= '0;
            pend_md_q  <= MD_NONE;
            pend_sub_q <= op_q == OP_MINUS;
            err_q      <= err_q | dz_div;
          end
        endcase
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply && (op_q == OP_EQUALS)) begin
      value_q <= sum;
      derr_q  <= err_q | dz_div;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign value_o        = PORT_WIDTH'($signed(value_q));
  assign divide_error_o = derr_q;

endmodule

/* hdl/iame_controller.sv */
// ----------------------------------------------------------------------------
// iame_controller
// Sequences one transaction: accept, iterate the multiply or divide unit
// when a chain is pending, then apply the term to the expression state.
// ----------------------------------------------------------------------------
module iame_controller import iame_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ctl_sts_t sts_i,
  output ctl_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = state_q != ST_IDLE;
  assign accept     = in_valid_i && (state_q == ST_IDLE) && sts_i.op_ok;

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o.load  = 1'b0;
    cmd_o.step  = 1'b0;
    cmd_o.apply = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.md_pending ? ST_CALC : ST_APPLY;
        end
      end
      ST_CALC: begin
        cmd_o.step = 1'b1;
        if (sts_i.calc_done) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (sts_i.apply_ok) begin
          cmd_o.apply = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hdl/infix_add_mul_evaluator.sv */
// ----------------------------------------------------------------------------
// infix_add_mul_evaluator: streaming infix evaluator with times/divide precedence.
// A transaction is accepted, then iterated through the one-bit-per-cycle multiply/divide
// unit when a times or divide chain is pending, then applied to the expression state.
// Reset clears the expression state and the result valid flag asynchronously.
// ----------------------------------------------------------------------------
module infix_add_mul_evaluator import iame_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PORT_WIDTH-1:0] operand_i,
  input  logic [2:0]            op_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PORT_WIDTH-1:0] value_o,
  output logic                  divide_error_o
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // Sequencing.
  iame_controller u_controller (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Arithmetic and state.
  iame_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .operand_i      (operand_i),
    .op_i           (op_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .value_o        (value_o),
    .divide_error_o (divide_error_o)
  );

endmodule

/* hdl/iame_checker.sv */
// ----------------------------------------------------------------------------
// iame_checker
// Port-level checks on the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`include "infix_add_mul_evaluator_defines.svh"

module iame_checker import iame_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic [2:0]            op_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [PORT_WIDTH-1:0] value_o,
  input logic                  divide_error_o
);

  // A stalled result transaction stays offered.
  `IAME_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")

  // A stalled result payload does not change.
  `IAME_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(value_o) && $stable(divide_error_o), "result payload changed while stalled")

  // An accepted defined operator leaves the input stalled in the next cycle.
  `IAME_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o && (op_i <= OP_EQUALS), in_stall_o, "input not stalled after a transaction")

  // A new result only appears out of the apply cycle, while input is stalled.
  `IAME_ASSERT_IMPLY(a_result_from_apply, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o), "result appeared without a busy cycle")

endmodule

bind infix_add_mul_evaluator iame_checker u_iame_checker (.*);
